/* hw/rtl/volume_label_bounding_box_assert.svh */
// ----------------------------------------------------------------------------
// volume label bounding box assertion macros
// shared property forms for the checker, clocked on clk and idle in reset
// ----------------------------------------------------------------------------
`ifndef VOLUME_LABEL_BOUNDING_BOX_ASSERT_SVH
`define VOLUME_LABEL_BOUNDING_BOX_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VLBB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vlbb: same-cycle property failed");

// antecedent implies consequent in the next cycle
`define VLBB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vlbb: next-cycle property failed");

`endif

/* hw/rtl/vlbb_pkg.sv */
// ----------------------------------------------------------------------------
// vlbb_pkg
// widths, register codes and shared types of the volume label bounding box
// ----------------------------------------------------------------------------
package vlbb_pkg;

  localparam int unsigned SIZE_W  = 12;
  localparam int unsigned PAD_W   = 11;
  localparam int unsigned LABEL_W = 16;
  localparam int unsigned OUT_W   = 11;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 4;

  localparam int unsigned MAX_DIM_DEFAULT = 2048;

  localparam logic [OUT_W-1:0]   OUT_MAX      = 11'd2047;
  localparam logic [SIZE_W-1:0]  SIZE_RESET   = 12'd2048;
  localparam logic [PAD_W-1:0]   PAD_RESET    = 11'd0;
  localparam logic [LABEL_W-1:0] OBJECT_LABEL = 16'd1;

  // register index codes (byte address bits 3:2)
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [1:0] REG_PAD    = 2'd3;

  // per-item control handed to every axis tracker
  typedef struct packed {
    logic step;   // item leaves the input register this cycle
    logic hit;    // item carries the object label
    logic seen;   // object seen earlier in this volume
    logic last;   // item closes the volume
  } axis_ctrl_t;

endpackage

/* hw/rtl/vlbb_axis.sv */
// ----------------------------------------------------------------------------
// vlbb_axis
// position counter, extent tracking and padded box bounds for one axis
// ----------------------------------------------------------------------------
module vlbb_axis #(
  parameter int unsigned POS_W = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  vlbb_pkg::axis_ctrl_t        ctrl,
  input  logic                        carry,
  input  logic [POS_W-1:0]            size_m1,
  input  logic [vlbb_pkg::PAD_W-1:0]  pad_amount,
  output logic                        wrap,
  output logic [vlbb_pkg::OUT_W-1:0]  box_start,
  output logic [vlbb_pkg::OUT_W-1:0]  box_end
);

  localparam int unsigned AW =
    ((POS_W > vlbb_pkg::SIZE_W) ? POS_W : vlbb_pkg::SIZE_W) + 1;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] lo;
  logic [POS_W-1:0] hi;
  logic [POS_W-1:0] lo_next;
  logic [POS_W-1:0] hi_next;
  logic             seen_now;
  logic [AW-1:0]    base;
  logic [AW-1:0]    pad_w;
  logic [AW-1:0]    start_w;
  logic [AW-1:0]    end_w;

  assign wrap = (pos >= size_m1);

  // extent including the current item
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (ctrl.hit) begin
      if (!ctrl.seen || pos < lo) lo_next = pos;
      if (!ctrl.seen || pos > hi) hi_next = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (ctrl.step) begin
      if (ctrl.last) begin
        pos <= '0;
      end else if (carry) begin
        pos <= wrap ? '0 : pos + POS_W'(1);
      end
    end
  end

  // lo and hi are only read once the object has been seen
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

  // padded bounds, empty volume falls back to size and zero
  always_comb begin
    seen_now = ctrl.seen | ctrl.hit;
    pad_w    = AW'(pad_amount);
    base     = seen_now ? AW'(lo_next) : AW'(size_m1) + AW'(1);
    start_w  = (base > pad_w) ? base - pad_w : '0;
    end_w    = (seen_now ? AW'(hi_next) : '0) + pad_w;
    if (end_w > AW'(size_m1)) end_w = AW'(size_m1);
    box_start = (start_w > AW'(vlbb_pkg::OUT_MAX)) ? vlbb_pkg::OUT_MAX
                                                   : start_w[vlbb_pkg::OUT_W-1:0];
    box_end   = (end_w > AW'(vlbb_pkg::OUT_MAX)) ? vlbb_pkg::OUT_MAX
                                                 : end_w[vlbb_pkg::OUT_W-1:0];
  end

endmodule

/* hw/rtl/volume_label_bounding_box.sv */
// ----------------------------------------------------------------------------
// volume_label_bounding_box
// padded 3d bounding box of the voxels labelled 1 in a raster-order stream
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  voxel     voxel_valid/stall    voxel_label, last_voxel
//  box       box_valid/stall      box_start_*, box_end_*, object_found
//  config    apb (psel..pready)   size_x, size_y, size_z, pad_amount
//
//  one voxel item per cycle while voxel_stall is low; a box item appears after its last voxel
//  is accepted, passing through the input register and then the result register
//  voxel_stall rises only when a last voxel sits in the input register while
//  an earlier box item is still held by box_stall
//  synchronous reset: sizes 2048, pad 0, counters and the object seen flag cleared
//  sizes of 0 act as 1, sizes above MAX_DIM act as MAX_DIM
//
module volume_label_bounding_box #(
  parameter int unsigned MAX_DIM = vlbb_pkg::MAX_DIM_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // voxel stream
  input  logic                          voxel_valid,
  output logic                          voxel_stall,
  input  logic [vlbb_pkg::LABEL_W-1:0]  voxel_label,
  input  logic                          last_voxel,
  // box results
  output logic                          box_valid,
  input  logic                          box_stall,
  output logic [vlbb_pkg::OUT_W-1:0]    box_start_x,
  output logic [vlbb_pkg::OUT_W-1:0]    box_start_y,
  output logic [vlbb_pkg::OUT_W-1:0]    box_start_z,
  output logic [vlbb_pkg::OUT_W-1:0]    box_end_x,
  output logic [vlbb_pkg::OUT_W-1:0]    box_end_y,
  output logic [vlbb_pkg::OUT_W-1:0]    box_end_z,
  output logic                          object_found,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vlbb_pkg::ADDR_W-1:0]   paddr,
  input  logic [vlbb_pkg::DATA_W-1:0]   pwdata,
  output logic [vlbb_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned POS_W = $clog2(MAX_DIM);
  localparam int unsigned AW =
    ((POS_W > vlbb_pkg::SIZE_W) ? POS_W : vlbb_pkg::SIZE_W) + 1;

  // size register value to last valid position, clamped to 1..MAX_DIM
  function automatic logic [POS_W-1:0] size_to_m1(input logic [vlbb_pkg::SIZE_W-1:0] s);
    logic [AW-1:0] e;
    e = AW'(s);
    if (e == '0) e = AW'(1);
    else if (e > AW'(MAX_DIM)) e = AW'(MAX_DIM);
    return POS_W'(e - AW'(1));
  endfunction

  // configuration registers as written, plus the clamped form used by the axes
  logic [vlbb_pkg::SIZE_W-1:0] size_x;
  logic [vlbb_pkg::SIZE_W-1:0] size_y;
  logic [vlbb_pkg::SIZE_W-1:0] size_z;
  logic [vlbb_pkg::PAD_W-1:0]  pad_amount;
  logic [POS_W-1:0]            size_m1_x;
  logic [POS_W-1:0]            size_m1_y;
  logic [POS_W-1:0]            size_m1_z;
  logic                        cfg_write;

  // input register
  logic                        in_valid;
  logic                        in_hit;
  logic                        in_last;

  // volume tracking
  logic                        seen;
  logic                        advance;
  vlbb_pkg::axis_ctrl_t        ctrl;
  logic                        wrap_x;
  logic                        wrap_y;
  logic                        wrap_z;
  logic [vlbb_pkg::OUT_W-1:0]  start_x;
  logic [vlbb_pkg::OUT_W-1:0]  start_y;
  logic [vlbb_pkg::OUT_W-1:0]  start_z;
  logic [vlbb_pkg::OUT_W-1:0]  end_x;
  logic [vlbb_pkg::OUT_W-1:0]  end_y;
  logic [vlbb_pkg::OUT_W-1:0]  end_z;

  // ---------------------------------------------------------------------------
  // register port, zero wait states
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x     <= vlbb_pkg::SIZE_RESET;
      size_y     <= vlbb_pkg::SIZE_RESET;
      size_z     <= vlbb_pkg::SIZE_RESET;
      pad_amount <= vlbb_pkg::PAD_RESET;
      size_m1_x  <= size_to_m1(vlbb_pkg::SIZE_RESET);
      size_m1_y  <= size_to_m1(vlbb_pkg::SIZE_RESET);
      size_m1_z  <= size_to_m1(vlbb_pkg::SIZE_RESET);
    end else if (cfg_write) begin
      case (paddr[3:2])
        vlbb_pkg::REG_SIZE_X: begin
          size_x    <= pwdata[vlbb_pkg::SIZE_W-1:0];
          size_m1_x <= size_to_m1(pwdata[vlbb_pkg::SIZE_W-1:0]);
        end
        vlbb_pkg::REG_SIZE_Y: begin
          size_y    <= pwdata[vlbb_pkg::SIZE_W-1:0];
          size_m1_y <= size_to_m1(pwdata[vlbb_pkg::SIZE_W-1:0]);
        end
        vlbb_pkg::REG_SIZE_Z: begin
          size_z    <= pwdata[vlbb_pkg::SIZE_W-1:0];
          size_m1_z <= size_to_m1(pwdata[vlbb_pkg::SIZE_W-1:0]);
        end
        vlbb_pkg::REG_PAD: begin
          pad_amount <= pwdata[vlbb_pkg::PAD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      vlbb_pkg::REG_SIZE_X: prdata = vlbb_pkg::DATA_W'(size_x);
      vlbb_pkg::REG_SIZE_Y: prdata = vlbb_pkg::DATA_W'(size_y);
      vlbb_pkg::REG_SIZE_Z: prdata = vlbb_pkg::DATA_W'(size_z);
      vlbb_pkg::REG_PAD:    prdata = vlbb_pkg::DATA_W'(pad_amount);
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: only a last voxel needs the result register, so ordinary
  // voxels keep flowing while a box item waits to be taken
  // ---------------------------------------------------------------------------
  assign advance     = in_valid && !(in_last && box_valid && box_stall);
  assign voxel_stall = in_valid && !advance;

  // input register, label reduced to a match flag on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (voxel_valid && !voxel_stall) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (voxel_valid && !voxel_stall) begin
      in_hit  <= (voxel_label == vlbb_pkg::OBJECT_LABEL);
      in_last <= last_voxel;
    end
  end

  // object seen flag for the current volume, cleared after the last voxel
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (advance) begin
      seen <= in_last ? 1'b0 : (seen | in_hit);
    end
  end

  assign ctrl.step = advance;
  assign ctrl.hit  = in_hit;
  assign ctrl.seen = seen;
  assign ctrl.last = in_last;

  // ---------------------------------------------------------------------------
  // axis trackers: x steps on every voxel, y when x wraps, z when both wrap
  // ---------------------------------------------------------------------------
  vlbb_axis #(.POS_W(POS_W)) u_axis_x (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .carry      (1'b1),
    .size_m1    (size_m1_x),
    .pad_amount (pad_amount),
    .wrap       (wrap_x),
    .box_start  (start_x),
    .box_end    (end_x)
  );

  vlbb_axis #(.POS_W(POS_W)) u_axis_y (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .carry      (wrap_x),
    .size_m1    (size_m1_y),
    .pad_amount (pad_amount),
    .wrap       (wrap_y),
    .box_start  (start_y),
    .box_end    (end_y)
  );

  // z wrap is not needed further up, it only closes the counter
  vlbb_axis #(.POS_W(POS_W)) u_axis_z (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .carry      (wrap_x && wrap_y),
    .size_m1    (size_m1_z),
    .pad_amount (pad_amount),
    .wrap       (wrap_z),
    .box_start  (start_z),
    .box_end    (end_z)
  );

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (advance && in_last) begin
      box_valid <= 1'b1;
    end else if (!box_stall) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      box_start_x  <= start_x;
      box_start_y  <= start_y;
      box_start_z  <= start_z;
      box_end_x    <= end_x;
      box_end_y    <= end_y;
      box_end_z    <= end_z;
      object_found <= seen | in_hit;
    end
  end

  // z wrap carries no further; kept visible for debug taps
  logic unused_wrap_z;
  assign unused_wrap_z = wrap_z;

endmodule

/* hw/rtl/vlbb_checker.sv */
// ----------------------------------------------------------------------------
// vlbb_checker
// port-level properties of the volume label bounding box, bound to the top
// ----------------------------------------------------------------------------
`include "volume_label_bounding_box_assert.svh"

module vlbb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          voxel_valid,
  input logic                          voxel_stall,
  input logic                          last_voxel,
  input logic                          box_valid,
  input logic                          box_stall,
  input logic [vlbb_pkg::OUT_W-1:0]    box_start_x,
  input logic [vlbb_pkg::OUT_W-1:0]    box_end_x,
  input logic                          object_found
);

  // a held box item keeps its payload
  `VLBB_ASSERT_NEXT(a_box_hold, box_valid && box_stall,
                    box_valid && $stable(box_start_x) && $stable(box_end_x) && $stable(object_found))

  // the voxel side only stalls behind a blocked box item
  `VLBB_ASSERT_SAME(a_stall_cause, voxel_stall, box_valid && box_stall)

  // a fresh box item comes from an accepted last voxel that passed the input and result registers
  `VLBB_ASSERT_SAME(a_box_origin, $rose(box_valid),
                    $past(voxel_valid && !voxel_stall && last_voxel, 2))

endmodule

bind volume_label_bounding_box vlbb_checker u_vlbb_checker (
  .clk          (clk),
  .rst          (rst),
  .voxel_valid  (voxel_valid),
  .voxel_stall  (voxel_stall),
  .last_voxel   (last_voxel),
  .box_valid    (box_valid),
  .box_stall    (box_stall),
  .box_start_x  (box_start_x),
  .box_end_x    (box_end_x),
  .object_found (object_found)
);

/* tb/vlbb_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vlbb_tb_pkg
// box item type and scoreboard for the volume label bounding box bench
// ----------------------------------------------------------------------------
package vlbb_tb_pkg;

  import vlbb_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] start_x;
    logic [OUT_W-1:0] start_y;
    logic [OUT_W-1:0] start_z;
    logic [OUT_W-1:0] end_x;
    logic [OUT_W-1:0] end_y;
    logic [OUT_W-1:0] end_z;
    logic             found;
  } box_t;

  function automatic string show_box(box_t b);
    return $sformatf("start (%0d,%0d,%0d) end (%0d,%0d,%0d) found %0d",
                     b.start_x, b.start_y, b.start_z, b.end_x, b.end_y, b.end_z,
                     b.found);
  endfunction

  class box_scoreboard;
    int unsigned axis_size [3];
    int unsigned pad;
    int unsigned pos [3];
    int unsigned lo [3];
    int unsigned hi [3];
    bit          seen;
    box_t        boxes_due [$];
    int unsigned faults;

    function new();
      axis_size = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
      pad       = PAD_RESET;
      faults    = 0;
      clear_volume();
    endfunction

    function void clear_volume();
      pos  = '{0, 0, 0};
      lo   = '{0, 0, 0};
      hi   = '{0, 0, 0};
      seen = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] word);
      case (idx)
        REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: axis_size[idx] = word[SIZE_W-1:0];
        REG_PAD: pad = word[PAD_W-1:0];
        default: ;
      endcase
    endfunction

    // size as the block uses it: 0 acts as 1, above the limit acts as the limit
    function int unsigned axis_len(int a);
      if (axis_size[a] < 1) return 1;
      if (axis_size[a] > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
      return axis_size[a];
    endfunction

    function int unsigned start_of(int a, int unsigned n);
      int unsigned base;
      int unsigned v;
      base = seen ? lo[a] : n;
      v = (base > pad) ? base - pad : 0;
      return (v > OUT_MAX) ? OUT_MAX : v;
    endfunction

    function int unsigned end_of(int a, int unsigned n);
      int unsigned e;
      e = (seen ? hi[a] : 0) + pad;
      if (e > n - 1) e = n - 1;
      return (e > OUT_MAX) ? OUT_MAX : e;
    endfunction

    function void note_voxel(logic [LABEL_W-1:0] label, logic last);
      int unsigned len [3];
      box_t        b;
      for (int a = 0; a < 3; a++) len[a] = axis_len(a);
      if (label == OBJECT_LABEL) begin
        for (int a = 0; a < 3; a++) begin
          if (!seen || pos[a] < lo[a]) lo[a] = pos[a];
          if (!seen || pos[a] > hi[a]) hi[a] = pos[a];
        end
        seen = 1'b1;
      end
      if (last) begin
        b.start_x = OUT_W'(start_of(0, len[0]));
        b.start_y = OUT_W'(start_of(1, len[1]));
        b.start_z = OUT_W'(start_of(2, len[2]));
        b.end_x   = OUT_W'(end_of(0, len[0]));
        b.end_y   = OUT_W'(end_of(1, len[1]));
        b.end_z   = OUT_W'(end_of(2, len[2]));
        b.found   = seen;
        boxes_due.push_back(b);
        clear_volume();
        return;
      end
      // raster advance, a counter past its size wraps on the next step
      for (int a = 0; a < 3; a++) begin
        if (pos[a] < len[a] - 1) begin
          pos[a]++;
          break;
        end
        pos[a] = 0;
      end
    endfunction

    function void check_box(box_t got);
      box_t want;
      if (boxes_due.size() == 0) begin
        faults++;
        if (faults <= 10) $display("box item with none due: got %s", show_box(got));
        return;
      end
      want = boxes_due.pop_front();
      if (got !== want) begin
        faults++;
        if (faults <= 10)
          $display("box mismatch: expected %s, got %s", show_box(want), show_box(got));
      end
    endfunction

    function int pending();
      return boxes_due.size();
    endfunction
  endclass

endpackage

/* tb/volume_label_bounding_box_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// volume_label_bounding_box_tb
// streams voxel volumes through the bounding box block under random gaps
// and output stalls, predicts each box item and checks it on arrival
// ----------------------------------------------------------------------------
module volume_label_bounding_box_tb;

  import vlbb_pkg::*;
  import vlbb_tb_pkg::*;

  // settle margin; a box item passes the input register and the result register after its last voxel
  localparam int SETTLE = 4;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_HEAVY} rx_mode_t;

  logic                clk;
  logic                rst;
  logic                voxel_valid;
  logic                voxel_stall;
  logic [LABEL_W-1:0]  voxel_label;
  logic                last_voxel;
  logic                box_valid;
  logic                box_stall;
  logic [OUT_W-1:0]    box_start_x;
  logic [OUT_W-1:0]    box_start_y;
  logic [OUT_W-1:0]    box_start_z;
  logic [OUT_W-1:0]    box_end_x;
  logic [OUT_W-1:0]    box_end_y;
  logic [OUT_W-1:0]    box_end_z;
  logic                object_found;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  box_scoreboard store;

  // sender burst state
  int unsigned burst_left;
  bit          steady;
  int unsigned n_voxels;
  int unsigned n_volumes;

  // receiver stall pattern state
  rx_mode_t    rx_mode;
  int unsigned rx_left;

  volume_label_bounding_box u_top (
    .clk          (clk),
    .rst          (rst),
    .voxel_valid  (voxel_valid),
    .voxel_stall  (voxel_stall),
    .voxel_label  (voxel_label),
    .last_voxel   (last_voxel),
    .box_valid    (box_valid),
    .box_stall    (box_stall),
    .box_start_x  (box_start_x),
    .box_start_y  (box_start_y),
    .box_start_z  (box_start_z),
    .box_end_x    (box_end_x),
    .box_end_y    (box_end_y),
    .box_end_z    (box_end_z),
    .object_found (object_found),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: open, scattered or heavy stalling, each held for a random stretch
  initial begin
    rx_left   = 0;
    rx_mode   = RX_OPEN;
    box_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   box_stall <= 1'b0;
        RX_RANDOM: box_stall <= ($urandom_range(0, 2) == 0);
        default:   box_stall <= ((rx_left % 9) < 6);
      endcase
    end
  end

  // box items are taken at the edge where valid is high and stall low;
  // values read here are the ones from before the edge
  always @(posedge clk) begin
    if (!rst && box_valid && !box_stall)
      store.check_box({box_start_x, box_start_y, box_start_z,
                       box_end_x, box_end_y, box_end_z, object_found});
  end

  // one voxel item; a burst boundary inserts a gap before it
  task automatic send_voxel(input logic [LABEL_W-1:0] label, input logic last);
    if (burst_left == 0) begin
      voxel_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = steady ? 400 : $urandom_range(1, 16);
    end
    burst_left--;
    voxel_valid <= 1'b1;
    voxel_label <= label;
    last_voxel  <= last;
    do @(posedge clk); while (voxel_stall);
    store.note_voxel(label, last);
    n_voxels++;
  endtask

  // drain: every box item in, then let the pipeline empty
  task automatic wait_idle();
    voxel_valid <= 1'b0;
    burst_left = 0;
    while (store.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write, setup then access; upper data bits carry noise
  task automatic apb_write(input logic [1:0] idx, input logic [SIZE_W-1:0] value);
    logic [DATA_W-1:0] word;
    word = $urandom;
    word[SIZE_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    store.write_reg(idx, word);
    @(posedge clk);
  endtask

  // mostly small sizes so that volumes wrap on every axis, now and then extremes
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ($urandom_range(0, 1) != 0) ? SIZE_W'(2048) : SIZE_W'(4095);
      2:       return SIZE_W'($urandom_range(1, 4095));
      default: return SIZE_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_pad();
    case ($urandom_range(0, 7))
      0:       return SIZE_W'(2047);
      1:       return SIZE_W'($urandom_range(0, 2047));
      default: return SIZE_W'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    int          len;
    int          hit_pct;
    longint      raster;
    logic [LABEL_W-1:0] label;

    store      = new();
    burst_left = 0;
    steady     = 1'b0;
    n_voxels   = 0;
    n_volumes  = 0;
    rst         <= 1'b1;
    voxel_valid <= 1'b0;
    voxel_label <= '0;
    last_voxel  <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: a lone labelled voxel at the origin, then two empty volumes
    // whose start of size minus pad overflows the field and saturates
    send_voxel(16'h0001, 1'b1);
    send_voxel(16'h0000, 1'b1);
    send_voxel(16'hFFFF, 1'b1);
    wait_idle();

    // full 2x2x2 raster with padding, hits on two corners
    apb_write(REG_SIZE_X, SIZE_W'(2));
    apb_write(REG_SIZE_Y, SIZE_W'(2));
    apb_write(REG_SIZE_Z, SIZE_W'(2));
    apb_write(REG_PAD, SIZE_W'(1));
    for (int i = 0; i < 8; i++)
      send_voxel((i == 3 || i == 5) ? OBJECT_LABEL : 16'h0000, i == 7);
    wait_idle();

    // size 0 acts as 1, size 4095 acts as the limit, pad at its maximum;
    // empty volume with pad past the size, then a found one clamped both ways
    apb_write(REG_SIZE_X, SIZE_W'(1));
    apb_write(REG_SIZE_Y, SIZE_W'(0));
    apb_write(REG_SIZE_Z, SIZE_W'(4095));
    apb_write(REG_PAD, SIZE_W'(2047));
    send_voxel(16'h0002, 1'b1);
    send_voxel(OBJECT_LABEL, 1'b1);
    wait_idle();

    // sizes shrink in the middle of a volume: counters past the new size wrap
    apb_write(REG_SIZE_X, SIZE_W'(4));
    apb_write(REG_SIZE_Y, SIZE_W'(4));
    apb_write(REG_SIZE_Z, SIZE_W'(4));
    apb_write(REG_PAD, SIZE_W'(0));
    for (int i = 0; i < 10; i++)
      send_voxel((i == 9) ? OBJECT_LABEL : 16'h0000, 1'b0);
    wait_idle();
    apb_write(REG_SIZE_X, SIZE_W'(2));
    apb_write(REG_SIZE_Y, SIZE_W'(2));
    apb_write(REG_PAD, SIZE_W'(3));
    for (int i = 0; i < 3; i++) send_voxel(OBJECT_LABEL, i == 2);
    // empty volume, pad above two sizes and below the third
    send_voxel(16'h0000, 1'b1);

    // random phases: fresh settings, then a few volumes, mostly whole rasters
    while (n_voxels < 1750 || n_volumes < 40) begin
      wait_idle();
      apb_write(REG_SIZE_X, pick_size());
      apb_write(REG_SIZE_Y, pick_size());
      apb_write(REG_SIZE_Z, pick_size());
      apb_write(REG_PAD, pick_pad());
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) begin
        raster = longint'(store.axis_len(0)) * store.axis_len(1) * store.axis_len(2);
        if (raster <= 150 && $urandom_range(0, 3) != 0)
          len = int'(raster) * (($urandom_range(0, 4) == 0) ? 2 : 1);
        else
          len = $urandom_range(1, 48);
        case ($urandom_range(0, 3))
          0:       hit_pct = 0;
          1:       hit_pct = 3;
          2:       hit_pct = 20;
          default: hit_pct = 60;
        endcase
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < hit_pct)
            label = OBJECT_LABEL;
          else
            label = ($urandom_range(0, 1) != 0) ? 16'h0000 : LABEL_W'($urandom);
          send_voxel(label, i == len - 1);
        end
        n_volumes++;
      end
    end

    wait_idle();
    if (store.faults == 0 && store.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard limit, far beyond the slowest correct run
  initial begin
    #(5_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
